// File: rtl/vmqs_pkg.sv
`timescale 1ns / 1ps
package vmqs_pkg;

  // field widths
  localparam int ACT_W      = 12;
  localparam int TOT_W      = 13;
  localparam int KHZ_W      = 20;
  localparam int IDX_W      = 8;
  localparam int HZ_W       = 30;
  localparam int AREA_W     = 2 * ACT_W;
  localparam int BW_W       = 54;
  localparam int BEST_BW_W  = 32;
  localparam int CFG_W      = 32;
  localparam int REG_IDX_W  = 3;

  localparam int KHZ_TO_HZ   = 1000;
  localparam int MAX_MODES   = 256;
  localparam int MODES_CMP_W = 13;

  localparam logic [ACT_W-1:0] MAX_WIDTH_RST     = 12'd1920;
  localparam logic [ACT_W-1:0] MAX_HEIGHT_RST    = 12'd1080;
  localparam logic [CFG_W-1:0] MAX_BANDWIDTH_RST = 32'd124416000;
  localparam logic [CFG_W-1:0] REF_CLOCK_A_RST   = 32'd540000000;
  localparam logic [CFG_W-1:0] REF_CLOCK_B_RST   = 32'd297000000;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_MAX_WIDTH     = 3'd0,
    REG_MAX_HEIGHT    = 3'd1,
    REG_MAX_BANDWIDTH = 3'd2,
    REG_REF_CLOCK_A   = 3'd3,
    REG_REF_CLOCK_B   = 3'd4
  } vmqs_reg_t;

  // one checked mode with its qualify flag, handed to the selector at commit
  typedef struct packed {
    logic             ok;
    logic             pref;
    logic [IDX_W-1:0] idx;
    logic [BW_W-1:0]  bw;
    logic             last;
  } vmqs_cand_t;

  // choice after this mode has been taken into account
  typedef struct packed {
    logic                 found;
    logic [IDX_W-1:0]     idx;
    logic [BEST_BW_W-1:0] bw;
  } vmqs_choice_t;

endpackage

// File: rtl/vmqs_div.sv
`timescale 1ns / 1ps
module vmqs_div #(
  parameter int NUM_W = 30,
  parameter int DEN_W = 13
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot,
  output logic [DEN_W-1:0] rem
);

  localparam int CW = $clog2(NUM_W);

  logic             busy;
  logic [CW-1:0]    cnt;
  logic [NUM_W-1:0] nq;
  logic [DEN_W-1:0] r;
  logic [DEN_W-1:0] d;
  logic [DEN_W:0]   shifted;
  logic [DEN_W+1:0] diff;
  logic             borrow;

  // restoring division, one quotient bit per cycle, MSB first
  always_comb begin
    shifted = {r, nq[NUM_W-1]};
    diff    = {1'b0, shifted} - {2'b00, d};
    borrow  = diff[DEN_W+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NUM_W - 1);
        nq   <= num;
        r    <= '0;
        d    <= den;
      end else if (busy) begin
        nq  <= {nq[NUM_W-2:0], ~borrow};
        r   <= borrow ? shifted[DEN_W-1:0] : diff[DEN_W-1:0];
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = nq;
  assign rem  = r;

  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider restarted while busy");

endmodule

// File: rtl/vmqs_mul.sv
`timescale 1ns / 1ps
module vmqs_mul #(
  parameter int A_W = 24,
  parameter int B_W = 30
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic               done,
  output logic [A_W+B_W-1:0] prod
);

  localparam int P_W = A_W + B_W;
  localparam int CW  = $clog2(B_W);

  logic           busy;
  logic [CW-1:0]  cnt;
  logic [A_W-1:0] areg;
  logic [B_W-1:0] bsh;
  logic [P_W-1:0] acc;
  logic [P_W-1:0] acc_next;

  // shift-add, one multiplier bit per cycle, MSB first
  assign acc_next = {acc[P_W-2:0], 1'b0} + (bsh[B_W-1] ? P_W'(areg) : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(B_W - 1);
        areg <= a;
        bsh  <= b;
        acc  <= '0;
      end else if (busy) begin
        acc <= acc_next;
        bsh <= {bsh[B_W-2:0], 1'b0};
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign prod = acc;

endmodule

// File: rtl/vmqs_select.sv
`timescale 1ns / 1ps
module vmqs_select import vmqs_pkg::*; #(
  parameter int N_MODES = MAX_MODES
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         commit,
  input  vmqs_cand_t   cand,
  output vmqs_choice_t choice
);

  logic                 have_choice;
  logic                 choice_locked;
  logic [IDX_W-1:0]     chosen_index;
  logic [BEST_BW_W-1:0] chosen_bandwidth;

  logic                 have_next;
  logic                 locked_next;
  logic [IDX_W-1:0]     index_next;
  logic [BEST_BW_W-1:0] bandwidth_next;
  logic                 take;
  logic                 upd;

  always_comb begin
    take = cand.ok && !choice_locked &&
           (MODES_CMP_W'(cand.idx) < MODES_CMP_W'(N_MODES));
    upd  = take && (cand.pref || !have_choice || cand.bw > BW_W'(chosen_bandwidth));
    have_next      = have_choice || upd;
    locked_next    = choice_locked || (take && cand.pref);
    index_next     = upd ? cand.idx : chosen_index;
    bandwidth_next = upd ? cand.bw[BEST_BW_W-1:0] : chosen_bandwidth;

    choice.found = have_next;
    choice.idx   = have_next ? index_next : '0;
    choice.bw    = have_next ? bandwidth_next : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_choice      <= 1'b0;
      choice_locked    <= 1'b0;
      chosen_index     <= '0;
      chosen_bandwidth <= '0;
    end else if (commit) begin
      // drop the choice after the last mode of a list
      if (cand.last) begin
        have_choice      <= 1'b0;
        choice_locked    <= 1'b0;
        chosen_index     <= '0;
        chosen_bandwidth <= '0;
      end else begin
        have_choice      <= have_next;
        choice_locked    <= locked_next;
        chosen_index     <= index_next;
        chosen_bandwidth <= bandwidth_next;
      end
    end
  end

  a_lock_has_choice: assert property (@(posedge clk) disable iff (rst)
    choice_locked |-> have_choice)
    else $error("choice locked without a chosen mode");

endmodule

// File: rtl/video_mode_qualify_select.sv
`timescale 1ns / 1ps
// Checks one display timing mode per input transfer against the configured size,
// bandwidth and reference clock limits and reports, for each mode, whether it
// qualifies, its bandwidth (active pixels times rounded refresh rate) and the mode
// chosen so far in the current list; the choice clears after the mode flagged last.
// Each mode runs through three serial passes of 30 steps each, one bit per cycle:
// the two rounding divisions that yield the refresh rate share one divider, and
// the bandwidth comes from a shift-add multiplier. The clock divisibility checks
// run on two further dividers alongside the first division. The input stalls while
// a mode is in work; a result waits in the output register, so the next mode is
// taken meanwhile. Configuration writes are always ready and take effect at once.
module video_mode_qualify_select import vmqs_pkg::*; #(
  parameter int N_MODES = MAX_MODES
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [ACT_W-1:0]     h_active,
  input  logic [ACT_W-1:0]     v_active,
  input  logic [TOT_W-1:0]     h_total,
  input  logic [TOT_W-1:0]     v_total,
  input  logic [KHZ_W-1:0]     dot_clock_khz,
  input  logic                 interlaced,
  input  logic                 preferred,
  input  logic [IDX_W-1:0]     mode_index,
  input  logic                 last,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 mode_ok,
  output logic [BW_W-1:0]      mode_bandwidth,
  output logic                 found,
  output logic [IDX_W-1:0]     best_index,
  output logic [BEST_BW_W-1:0] best_bandwidth,
  output logic                 list_done
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_DIV1,
    S_DIV2,
    S_MUL,
    S_FIN
  } state_t;

  state_t state;

  logic [ACT_W-1:0] max_width;
  logic [ACT_W-1:0] max_height;
  logic [CFG_W-1:0] max_bandwidth;
  logic [CFG_W-1:0] ref_clock_a_hz;
  logic [CFG_W-1:0] ref_clock_b_hz;

  logic [ACT_W-1:0]  h_act_q;
  logic [ACT_W-1:0]  v_act_q;
  logic [TOT_W-1:0]  h_tot_q;
  logic [TOT_W-1:0]  v_tot_q;
  logic [HZ_W-1:0]   hz_q;
  logic [AREA_W-1:0] area_q;
  logic              inter_q;
  logic              pref_q;
  logic [IDX_W-1:0]  idx_q;
  logic              last_q;

  logic              rdiv_start;
  logic [HZ_W-1:0]   rdiv_num;
  logic [TOT_W-1:0]  rdiv_den;
  logic              rdiv_done;
  logic [HZ_W-1:0]   rdiv_quot;
  logic              cdiv_start;
  logic [HZ_W-1:0]   rem_a;
  logic [HZ_W-1:0]   rem_b;
  logic              mul_start;
  logic              mul_done;
  logic [BW_W-1:0]   mul_prod;

  logic              in_xfer;
  logic              commit;
  logic              tot_nz;
  vmqs_cand_t        cand;
  vmqs_choice_t      choice;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign commit    = (state == S_FIN) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_width      <= MAX_WIDTH_RST;
      max_height     <= MAX_HEIGHT_RST;
      max_bandwidth  <= MAX_BANDWIDTH_RST;
      ref_clock_a_hz <= REF_CLOCK_A_RST;
      ref_clock_b_hz <= REF_CLOCK_B_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (vmqs_reg_t'(cfg_index))
        REG_MAX_WIDTH:     max_width      <= cfg_data[ACT_W-1:0];
        REG_MAX_HEIGHT:    max_height     <= cfg_data[ACT_W-1:0];
        REG_MAX_BANDWIDTH: max_bandwidth  <= cfg_data;
        REG_REF_CLOCK_A:   ref_clock_a_hz <= cfg_data;
        REG_REF_CLOCK_B:   ref_clock_b_hz <= cfg_data;
        default: ;
      endcase
    end
  end

  // round(round(hz / h_total) / v_total) on the shared divider
  always_comb begin
    rdiv_start = (state == S_PREP) || ((state == S_DIV1) && rdiv_done);
    if (state == S_PREP) begin
      rdiv_num = hz_q + HZ_W'(h_tot_q >> 1);
      rdiv_den = h_tot_q;
    end else begin
      rdiv_num = rdiv_quot + HZ_W'(v_tot_q >> 1);
      rdiv_den = v_tot_q;
    end
    cdiv_start = (state == S_PREP);
    mul_start  = (state == S_DIV2) && rdiv_done;
  end

  vmqs_div #(.NUM_W(HZ_W), .DEN_W(TOT_W)) u_round_div (
    .clk  (clk),
    .rst  (rst),
    .start(rdiv_start),
    .num  (rdiv_num),
    .den  (rdiv_den),
    .done (rdiv_done),
    .quot (rdiv_quot),
    .rem  ()
  );

  vmqs_div #(.NUM_W(CFG_W), .DEN_W(HZ_W)) u_ref_a_div (
    .clk  (clk),
    .rst  (rst),
    .start(cdiv_start),
    .num  (ref_clock_a_hz),
    .den  (hz_q),
    .done (),
    .quot (),
    .rem  (rem_a)
  );

  vmqs_div #(.NUM_W(CFG_W), .DEN_W(HZ_W)) u_ref_b_div (
    .clk  (clk),
    .rst  (rst),
    .start(cdiv_start),
    .num  (ref_clock_b_hz),
    .den  (hz_q),
    .done (),
    .quot (),
    .rem  (rem_b)
  );

  vmqs_mul #(.A_W(AREA_W), .B_W(HZ_W)) u_bw_mul (
    .clk  (clk),
    .rst  (rst),
    .start(mul_start),
    .a    (area_q),
    .b    (rdiv_quot),
    .done (mul_done),
    .prod (mul_prod)
  );

  always_comb begin
    tot_nz    = (h_tot_q != '0) && (v_tot_q != '0);
    cand.bw   = tot_nz ? mul_prod : '0;
    cand.ok   = tot_nz && (hz_q != '0) &&
                (h_act_q <= max_width) && (v_act_q <= max_height) &&
                (cand.bw <= BW_W'(max_bandwidth)) && !inter_q &&
                ((rem_a == '0) || (rem_b == '0));
    cand.pref = pref_q;
    cand.idx  = idx_q;
    cand.last = last_q;
  end

  vmqs_select #(.N_MODES(N_MODES)) u_select (
    .clk   (clk),
    .rst   (rst),
    .commit(commit),
    .cand  (cand),
    .choice(choice)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !commit) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            h_act_q <= h_active;
            v_act_q <= v_active;
            h_tot_q <= h_total;
            v_tot_q <= v_total;
            hz_q    <= HZ_W'(dot_clock_khz * KHZ_TO_HZ);
            area_q  <= AREA_W'(h_active) * AREA_W'(v_active);
            inter_q <= interlaced;
            pref_q  <= preferred;
            idx_q   <= mode_index;
            last_q  <= last;
            state   <= S_PREP;
          end
        end
        S_PREP: state <= S_DIV1;
        S_DIV1: if (rdiv_done) state <= S_DIV2;
        S_DIV2: if (rdiv_done) state <= S_MUL;
        S_MUL:  if (mul_done) state <= S_FIN;
        S_FIN: begin
          // hold until the output register is free
          if (commit) begin
            out_valid      <= 1'b1;
            mode_ok        <= cand.ok;
            mode_bandwidth <= cand.bw;
            found          <= choice.found;
            best_index     <= choice.idx;
            best_bandwidth <= choice.bw;
            list_done      <= cand.last;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_after_xfer: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> in_stall)
    else $error("input not stalled after a transfer");

  a_ok_within_limit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && mode_ok) |-> (mode_bandwidth <= BW_W'(max_bandwidth)))
    else $error("qualified mode above bandwidth limit");

  a_no_choice_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> ((best_index == '0) && (best_bandwidth == '0)))
    else $error("choice fields set without a chosen mode");

endmodule
